// ===== design/tal_pkg.sv =====
// ----------------------------------------------------------------------------
// tal_pkg
// Shared types and constants for the lowest common ancestor engine.
// ----------------------------------------------------------------------------
package tal_pkg;

   // node numbers and the csr field have fixed widths on the ports
   localparam int NODE_W     = 10;
   localparam int LEVEL_W    = 5;   // holds any jump level up to the largest supported count
   localparam int LEVELS_W   = 4;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam int DEF_NODE_COUNT  = 1024;
   localparam int DEF_JUMP_LEVELS = 10;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [LEVELS_W-1:0] levels_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam levels_type LEVELS_RESET = 4'd9;

   localparam logic KIND_ATTACH = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ATTACHED = 2'd1;
   localparam status_type ST_MISSING  = 2'd2;

   // jump table read and write requests
   typedef struct packed {
      logic      en;
      node_type  node;
      level_type level;
   } anc_rd_type;

   typedef struct packed {
      logic      en;
      node_type  node;
      level_type level;
      node_type  data;
   } anc_wr_type;

   // depth store access, read or write address
   typedef struct packed {
      logic     en;
      node_type node;
   } dep_req_type;

endpackage

// ===== design/tal_store.sv =====
// ----------------------------------------------------------------------------
// tal_store
// Jump table and depth store memories with registered reads, and the
// depth store clearing sweep after reset.
// ----------------------------------------------------------------------------
module tal_store #(
   parameter int NODE_COUNT  = tal_pkg::DEF_NODE_COUNT,
   parameter int JUMP_LEVELS = tal_pkg::DEF_JUMP_LEVELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tal_pkg::anc_rd_type               anc_rd,
   output tal_pkg::node_type                 anc_rd_data,
   input  tal_pkg::anc_wr_type               anc_wr,
   input  tal_pkg::dep_req_type              dep_rd,
   output logic [$clog2(NODE_COUNT+1)-1:0]   dep_rd_data,
   input  tal_pkg::dep_req_type              dep_wr,
   input  logic [$clog2(NODE_COUNT+1)-1:0]   dep_wr_data,
   output logic                              clear_busy
);

   localparam int DEPTH_W   = $clog2(NODE_COUNT + 1);
   localparam int NODE_AW   = $clog2(NODE_COUNT);
   localparam int ANC_DEPTH = NODE_COUNT * JUMP_LEVELS;
   localparam int ANC_AW    = $clog2(ANC_DEPTH);

   tal_pkg::node_type  anc_mem [ANC_DEPTH];
   logic [DEPTH_W-1:0] dep_mem [NODE_COUNT];

   tal_pkg::node_type  anc_rd_data_ff;
   logic [DEPTH_W-1:0] dep_rd_data_ff;
   logic               clr_busy_ff, clr_busy_in;
   logic [NODE_AW-1:0] clr_idx_ff, clr_idx_in;

   logic [ANC_AW-1:0]  anc_rd_addr, anc_wr_addr;

   // entry (n, i) sits at n * levels + i
   assign anc_rd_addr = ANC_AW'(NODE_AW'(anc_rd.node)) * ANC_AW'(JUMP_LEVELS)
                        + ANC_AW'(anc_rd.level);
   assign anc_wr_addr = ANC_AW'(NODE_AW'(anc_wr.node)) * ANC_AW'(JUMP_LEVELS)
                        + ANC_AW'(anc_wr.level);

   always_ff @(posedge clock) begin
      if (anc_wr.en) begin
         anc_mem[anc_wr_addr] <= anc_wr.data;
      end
      if (anc_rd.en) begin
         anc_rd_data_ff <= anc_mem[anc_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dep_mem[clr_idx_ff] <= '0;
      end else if (dep_wr.en) begin
         dep_mem[NODE_AW'(dep_wr.node)] <= dep_wr_data;
      end
      if (dep_rd.en) begin
         dep_rd_data_ff <= dep_mem[NODE_AW'(dep_rd.node)];
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + NODE_AW'(1);
         if (clr_idx_ff == NODE_AW'(NODE_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   assign anc_rd_data = anc_rd_data_ff;
   assign dep_rd_data = dep_rd_data_ff;
   assign clear_busy  = clr_busy_ff;

endmodule

// ===== design/tree_ancestor_lca_engine.sv =====
// ----------------------------------------------------------------------------
// tree_ancestor_lca_engine
// Binary lifting lowest common ancestor engine: attaches nodes to a forest
// and answers common ancestor queries out of a jump table memory.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req_*    in         tuser kind, tdata node_first / node_second
//  rsp_*    out        tdata ancestor_node / status
//  csr_*    in         levels_in_use, write only
//
// one transaction is worked on at a time; its work is a chain of dependent
// jump table reads (one read port, registered read), which sets how long
// an attach or a query takes before rsp_tvalid.
// after reset the depth store is cleared, with req_tready low meanwhile.
// the result sits in an output register, so a stalled rsp side holds only the
// following transaction.
// ----------------------------------------------------------------------------
module tree_ancestor_lca_engine #(
   parameter int NODE_COUNT  = tal_pkg::DEF_NODE_COUNT,
   parameter int JUMP_LEVELS = tal_pkg::DEF_JUMP_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tal_pkg::REQ_DATA_W-1:0]  req_tdata,   // node_first, node_second, zero pad
   input  logic                            req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tal_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // ancestor_node, status, zero pad
   input  logic                            csr_wr_en,
   input  tal_pkg::levels_type             csr_wr_data  // levels_in_use
);

   localparam int DEPTH_W = $clog2(NODE_COUNT + 1);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_CHK_A    = 13'b0000000000010,
      S_CHK_B    = 13'b0000000000100,
      S_CHK_P    = 13'b0000000001000,
      S_FILL_RD  = 13'b0000000010000,
      S_FILL_WR  = 13'b0000000100000,
      S_LIFT     = 13'b0000001000000,
      S_LIFT_WR  = 13'b0000010000000,
      S_MEET     = 13'b0000100000000,
      S_JOIN_V   = 13'b0001000000000,
      S_JOIN_CMP = 13'b0010000000000,
      S_FINAL    = 13'b0100000000000,
      S_RESP     = 13'b1000000000000
   } state_type;

   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tal_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   tal_pkg::levels_type             csr_levels_ff, csr_levels_in;

   logic                            kind_ff, kind_in;
   tal_pkg::node_type               na_ff, na_in;
   tal_pkg::node_type               nb_ff, nb_in;
   tal_pkg::node_type               u_ff, u_in;
   tal_pkg::node_type               v_ff, v_in;
   tal_pkg::node_type               pu_ff, pu_in;
   tal_pkg::node_type               ans_ff, ans_in;
   tal_pkg::status_type             st_ff, st_in;
   tal_pkg::level_type              lvl_ff, lvl_in;
   logic [DEPTH_W-1:0]              pdep_ff, pdep_in;
   logic [DEPTH_W-1:0]              diff_ff, diff_in;
   logic                            zero_ff, zero_in;

   tal_pkg::anc_rd_type             anc_rd;
   tal_pkg::anc_wr_type             anc_wr;
   tal_pkg::node_type               anc_rd_data;
   tal_pkg::dep_req_type            dep_rd, dep_wr;
   logic [DEPTH_W-1:0]              dep_rd_data, dep_wr_data;
   logic                            clear_busy;

   logic                            req_fire;
   logic                            a_ok, b_ok;
   tal_pkg::level_type              top_lvl;
   tal_pkg::node_type               jump_val;
   logic [31:0]                     pow_lvl;
   logic                            lift_take;
   tal_pkg::node_type               u_next, v_next;

   tal_store #(
      .NODE_COUNT  (NODE_COUNT),
      .JUMP_LEVELS (JUMP_LEVELS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .anc_rd      (anc_rd),
      .anc_rd_data (anc_rd_data),
      .anc_wr      (anc_wr),
      .dep_rd      (dep_rd),
      .dep_rd_data (dep_rd_data),
      .dep_wr      (dep_wr),
      .dep_wr_data (dep_wr_data),
      .clear_busy  (clear_busy)
   );

   assign req_tready = (state_ff == S_IDLE) && !clear_busy;
   assign req_fire   = req_tvalid && req_tready;

   assign a_ok = (na_ff != '0) && (int'(na_ff) < NODE_COUNT);
   assign b_ok = (nb_ff != '0) && (int'(nb_ff) < NODE_COUNT);

   assign top_lvl = (int'(csr_levels_ff) > JUMP_LEVELS - 1) ?
                    tal_pkg::level_type'(JUMP_LEVELS - 1) :
                    tal_pkg::level_type'(csr_levels_ff);

   // node 0 is the sentinel, all of its jumps read as 0
   assign jump_val  = zero_ff ? '0 : anc_rd_data;
   assign pow_lvl   = 32'd1 << lvl_ff;
   // lifting by 2^i keeps v at or below u's depth exactly when the gap allows it
   assign lift_take = (32'(diff_ff) >= pow_lvl);
   assign u_next    = (pu_ff != jump_val) ? pu_ff : u_ff;
   assign v_next    = (pu_ff != jump_val) ? jump_val : v_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      csr_levels_in = csr_levels_ff;
      kind_in       = kind_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      pu_in         = pu_ff;
      ans_in        = ans_ff;
      st_in         = st_ff;
      lvl_in        = lvl_ff;
      pdep_in       = pdep_ff;
      diff_in       = diff_ff;
      zero_in       = zero_ff;
      anc_rd        = '0;
      anc_wr        = '0;
      dep_rd        = '0;
      dep_wr        = '0;
      dep_wr_data   = '0;

      if (csr_wr_en) begin
         csr_levels_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               na_in    = req_tdata[9:0];
               nb_in    = req_tdata[19:10];
               ans_in   = '0;
               st_in    = tal_pkg::ST_OK;
               state_in = S_CHK_A;
            end
         end
         S_CHK_A: begin
            if (!a_ok || (kind_ff == tal_pkg::KIND_QUERY && !b_ok)) begin
               st_in    = tal_pkg::ST_MISSING;
               state_in = S_RESP;
            end else begin
               dep_rd   = '{en: 1'b1, node: na_ff};
               state_in = S_CHK_B;
            end
         end
         S_CHK_B: begin
            if (kind_ff == tal_pkg::KIND_ATTACH) begin
               if (dep_rd_data != '0) begin
                  st_in    = tal_pkg::ST_ATTACHED;
                  state_in = S_RESP;
               end else if (nb_ff == '0) begin
                  // new root: level 0 jump is the sentinel
                  anc_wr   = '{en: 1'b1, node: na_ff, level: '0, data: nb_ff};
                  v_in     = nb_ff;
                  pdep_in  = '0;
                  lvl_in   = tal_pkg::level_type'(1);
                  state_in = S_FILL_RD;
               end else if (!b_ok) begin
                  st_in    = tal_pkg::ST_MISSING;
                  state_in = S_RESP;
               end else begin
                  dep_rd   = '{en: 1'b1, node: nb_ff};
                  state_in = S_CHK_P;
               end
            end else begin
               if (dep_rd_data == '0) begin
                  st_in    = tal_pkg::ST_MISSING;
                  state_in = S_RESP;
               end else begin
                  pdep_in  = dep_rd_data;
                  dep_rd   = '{en: 1'b1, node: nb_ff};
                  state_in = S_CHK_P;
               end
            end
         end
         S_CHK_P: begin
            if (dep_rd_data == '0) begin
               st_in    = tal_pkg::ST_MISSING;
               state_in = S_RESP;
            end else if (kind_ff == tal_pkg::KIND_ATTACH) begin
               anc_wr   = '{en: 1'b1, node: na_ff, level: '0, data: nb_ff};
               v_in     = nb_ff;
               pdep_in  = dep_rd_data;
               lvl_in   = tal_pkg::level_type'(1);
               state_in = S_FILL_RD;
            end else begin
               // u is the shallower node, v gets lifted
               if (pdep_ff > dep_rd_data) begin
                  u_in    = nb_ff;
                  v_in    = na_ff;
                  diff_in = pdep_ff - dep_rd_data;
               end else begin
                  u_in    = na_ff;
                  v_in    = nb_ff;
                  diff_in = dep_rd_data - pdep_ff;
               end
               lvl_in   = top_lvl;
               state_in = S_LIFT;
            end
         end
         S_FILL_RD: begin
            if (lvl_ff == tal_pkg::level_type'(JUMP_LEVELS)) begin
               dep_wr      = '{en: 1'b1, node: na_ff};
               dep_wr_data = pdep_ff + DEPTH_W'(1);
               state_in    = S_RESP;
            end else begin
               anc_rd   = '{en: 1'b1, node: v_ff, level: lvl_ff - tal_pkg::level_type'(1)};
               zero_in  = (v_ff == '0);
               state_in = S_FILL_WR;
            end
         end
         S_FILL_WR: begin
            anc_wr   = '{en: 1'b1, node: na_ff, level: lvl_ff, data: jump_val};
            v_in     = jump_val;
            lvl_in   = lvl_ff + tal_pkg::level_type'(1);
            state_in = S_FILL_RD;
         end
         S_LIFT: begin
            if (lift_take) begin
               anc_rd   = '{en: 1'b1, node: v_ff, level: lvl_ff};
               zero_in  = (v_ff == '0);
               state_in = S_LIFT_WR;
            end else if (lvl_ff == '0) begin
               state_in = S_MEET;
            end else begin
               lvl_in = lvl_ff - tal_pkg::level_type'(1);
            end
         end
         S_LIFT_WR: begin
            v_in    = jump_val;
            diff_in = diff_ff - DEPTH_W'(pow_lvl);
            if (lvl_ff == '0) begin
               state_in = S_MEET;
            end else begin
               lvl_in   = lvl_ff - tal_pkg::level_type'(1);
               state_in = S_LIFT;
            end
         end
         S_MEET: begin
            if (u_ff == v_ff) begin
               ans_in   = u_ff;
               state_in = S_RESP;
            end else begin
               lvl_in   = top_lvl;
               anc_rd   = '{en: 1'b1, node: u_ff, level: top_lvl};
               zero_in  = (u_ff == '0);
               state_in = S_JOIN_V;
            end
         end
         S_JOIN_V: begin
            pu_in    = jump_val;
            anc_rd   = '{en: 1'b1, node: v_ff, level: lvl_ff};
            zero_in  = (v_ff == '0);
            state_in = S_JOIN_CMP;
         end
         S_JOIN_CMP: begin
            // both climb only while their jumps differ
            u_in    = u_next;
            v_in    = v_next;
            zero_in = (u_next == '0);
            if (lvl_ff == '0) begin
               anc_rd   = '{en: 1'b1, node: u_next, level: '0};
               state_in = S_FINAL;
            end else begin
               anc_rd   = '{en: 1'b1, node: u_next, level: lvl_ff - tal_pkg::level_type'(1)};
               lvl_in   = lvl_ff - tal_pkg::level_type'(1);
               state_in = S_JOIN_V;
            end
         end
         S_FINAL: begin
            ans_in   = jump_val;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, st_ff, ans_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         csr_levels_ff <= tal_pkg::LEVELS_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         csr_levels_ff <= csr_levels_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      kind_ff     <= kind_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      pu_ff       <= pu_in;
      ans_ff      <= ans_in;
      st_ff       <= st_in;
      lvl_ff      <= lvl_in;
      pdep_ff     <= pdep_in;
      diff_ff     <= diff_in;
      zero_ff     <= zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_one_transaction: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction taken while one is in flight");

   a_error_no_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[11:10] != tal_pkg::ST_OK) |-> (rsp_tdata[9:0] == '0))
      else $error("failed transaction carries an ancestor");

   a_attach_no_answer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && kind_ff == tal_pkg::KIND_ATTACH) |-> (ans_ff == '0))
      else $error("attach result carries an ancestor");

   a_table_write: assert property (@(posedge clock) disable iff (reset)
      anc_wr.en |-> (kind_ff == tal_pkg::KIND_ATTACH &&
                     (state_ff == S_CHK_B || state_ff == S_CHK_P || state_ff == S_FILL_WR)))
      else $error("jump table written outside an attach");

endmodule

// ===== test/tb_tree_ancestor_lca_engine.sv =====
// ----------------------------------------------------------------------------
// tb_tree_ancestor_lca_engine
// Self-checking bench for the lowest common ancestor engine. Attach and query
// transactions go in on the req stream. A local binary lifting predictor of
// the forest works out each expected answer, and every rsp transaction is
// compared field by field in arrival order. Both stream sides idle at random,
// the rsp side holds off for a long stretch once, and levels_in_use is
// rewritten between phases, including zero and a saturating value.
// ----------------------------------------------------------------------------
module tb_tree_ancestor_lca_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES         = tal_pkg::DEF_NODE_COUNT;
   localparam int JUMPS         = tal_pkg::DEF_JUMP_LEVELS;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 60;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct {
      logic                kind;
      tal_pkg::node_type   first;
      tal_pkg::node_type   second;
      tal_pkg::node_type   anc;
      tal_pkg::status_type st;
   } lca_answer_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [tal_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [tal_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wr_en;
   tal_pkg::levels_type            csr_wr_data;

   // predictor state: jump table, depths (0 = not in the forest), register
   tal_pkg::node_type        jump_table [NODES][JUMPS];
   bit [tal_pkg::NODE_W:0]   node_depth [NODES];
   tal_pkg::levels_type      levels_now = tal_pkg::LEVELS_RESET;

   lca_answer_type    awaited_answers[$];
   tal_pkg::node_type placed[$];
   tal_pkg::node_type free_nodes[$];

   int error_count  = 0;
   int cycle_count  = 0;
   int req_calm     = 0;
   bit rsp_hold_req = 1'b0;

   tree_ancestor_lca_engine uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic bit is_placed(input tal_pkg::node_type n);
      return n != '0 && node_depth[n] != '0;
   endfunction

   function automatic tal_pkg::node_type hop(input tal_pkg::node_type n, input int lvl);
      if (n == '0) return '0;
      return jump_table[n][lvl];
   endfunction

   function automatic lca_answer_type lca_predict(input logic kind,
                                                  input tal_pkg::node_type a,
                                                  input tal_pkg::node_type b);
      lca_answer_type res;
      tal_pkg::node_type u, v, w, pu, pv;
      int top;
      res.kind = kind;
      res.first = a;
      res.second = b;
      res.anc = '0;
      res.st = tal_pkg::ST_OK;
      if (kind == tal_pkg::KIND_ATTACH) begin
         if (is_placed(a)) begin
            res.st = tal_pkg::ST_ATTACHED;
         end else if (a == '0 || (b != '0 && !is_placed(b))) begin
            res.st = tal_pkg::ST_MISSING;
         end else begin
            jump_table[a][0] = b;
            for (int i = 1; i < JUMPS; i++) jump_table[a][i] = hop(jump_table[a][i-1], i-1);
            node_depth[a] = node_depth[b] + 1'b1;
         end
      end else if (!is_placed(a) || !is_placed(b)) begin
         res.st = tal_pkg::ST_MISSING;
      end else begin
         top = (int'(levels_now) > JUMPS - 1) ? JUMPS - 1 : int'(levels_now);
         u = a;
         v = b;
         if (node_depth[u] > node_depth[v]) begin
            u = b;
            v = a;
         end
         // bring the deeper node up to the depth of the shallower one
         for (int i = top; i >= 0; i--) begin
            w = hop(v, i);
            if (node_depth[w] >= node_depth[u]) v = w;
         end
         if (u == v) begin
            res.anc = u;
         end else begin
            for (int i = top; i >= 0; i--) begin
               pu = hop(u, i);
               pv = hop(v, i);
               if (pu != pv) begin
                  u = pu;
                  v = pv;
               end
            end
            res.anc = hop(u, 0);
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // shared helpers
   // ------------------------------------------------------------------------
   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // called at a rising edge; leaves req_tvalid high when no gap follows
   task automatic send_item(input logic kind, input tal_pkg::node_type a,
                            input tal_pkg::node_type b);
      lca_answer_type res;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(tal_pkg::REQ_DATA_W - 2*tal_pkg::NODE_W){1'b0}}, b, a};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      res = lca_predict(kind, a, b);
      awaited_answers.insert(awaited_answers.size(), res);
      if (kind == tal_pkg::KIND_ATTACH && res.st == tal_pkg::ST_OK) begin
         placed.insert(placed.size(), a);
      end
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_levels(input tal_pkg::levels_type value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      levels_now = value;
   endtask

   function automatic bit take_free(output tal_pkg::node_type n);
      n = '0;
      while (free_nodes.size() != 0) begin
         n = free_nodes.pop_front();
         if (!is_placed(n)) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic random_item();
      int r;
      int pick;
      int span;
      logic kind;
      tal_pkg::node_type a, b;
      r = $urandom_range(0, 99);
      if (r < 40 && take_free(a)) begin
         kind = tal_pkg::KIND_ATTACH;
         pick = $urandom_range(0, 99);
         // prefer extending the newest node so the trees grow deep
         if (pick < 10 || placed.size() == 0) b = '0;
         else if (pick < 65) b = placed[placed.size()-1];
         else b = placed[$urandom_range(0, placed.size()-1)];
      end else if (r < 88 && placed.size() != 0) begin
         kind = tal_pkg::KIND_QUERY;
         a = placed[$urandom_range(0, placed.size()-1)];
         pick = $urandom_range(0, 99);
         span = (placed.size() > 8) ? 8 : placed.size() - 1;
         if (pick < 15) b = a;
         else if (pick < 45) b = placed[placed.size()-1-$urandom_range(0, span)];
         else b = placed[$urandom_range(0, placed.size()-1)];
         if ($urandom_range(0, 1)) begin
            {a, b} = {b, a};
         end
      end else begin
         kind = 1'($urandom_range(0, 1));
         a = tal_pkg::node_type'($urandom_range(0, NODES-1));
         b = tal_pkg::node_type'($urandom_range(0, NODES-1));
         pick = $urandom_range(0, 99);
         if (pick < 20) a = '0;
         else if (pick < 40) b = '0;
         else if (pick < 65 && placed.size() != 0) a = placed[$urandom_range(0, placed.size()-1)];
      end
      send_item(kind, a, b);
   endtask

   // ------------------------------------------------------------------------
   // rsp side: random ready, with a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(calm_left);
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      lca_answer_type want;
      tal_pkg::node_type got_anc;
      tal_pkg::status_type got_st;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got_anc = rsp_tdata[tal_pkg::NODE_W-1:0];
         got_st  = rsp_tdata[tal_pkg::NODE_W +: tal_pkg::STATUS_W];
         if (awaited_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, ancestor %0d status %0d",
                                      got_anc, got_st));
         end else begin
            want = awaited_answers.pop_front();
            if (got_anc !== want.anc)
               report_mismatch($sformatf("kind %0d (%0d,%0d): ancestor %0d, want %0d",
                                         want.kind, want.first, want.second, got_anc, want.anc));
            if (got_st !== want.st)
               report_mismatch($sformatf("kind %0d (%0d,%0d): status %0d, want %0d",
                                         want.kind, want.first, want.second, got_st, want.st));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_attach_rules();
      send_item(tal_pkg::KIND_ATTACH, 10'd1, 10'd0);      // root
      send_item(tal_pkg::KIND_ATTACH, 10'd2, 10'd1);
      send_item(tal_pkg::KIND_ATTACH, 10'd3, 10'd2);
      send_item(tal_pkg::KIND_ATTACH, 10'd4, 10'd2);
      send_item(tal_pkg::KIND_ATTACH, 10'd5, 10'd0);      // second tree
      send_item(tal_pkg::KIND_ATTACH, 10'd1023, 10'd3);   // highest node number
      send_item(tal_pkg::KIND_ATTACH, 10'd1, 10'd0);      // already attached
      send_item(tal_pkg::KIND_ATTACH, 10'd3, 10'd700);    // already attached beats missing parent
      send_item(tal_pkg::KIND_ATTACH, 10'd0, 10'd0);      // sentinel node
      send_item(tal_pkg::KIND_ATTACH, 10'd6, 10'd700);    // parent not attached
      send_item(tal_pkg::KIND_ATTACH, 10'd6, 10'd6);      // own parent, not attached
   endtask

   task automatic test_query_rules();
      send_item(tal_pkg::KIND_QUERY, 10'd3, 10'd4);       // siblings
      send_item(tal_pkg::KIND_QUERY, 10'd1023, 10'd4);    // different depths
      send_item(tal_pkg::KIND_QUERY, 10'd4, 10'd1023);
      send_item(tal_pkg::KIND_QUERY, 10'd3, 10'd3);       // same node
      send_item(tal_pkg::KIND_QUERY, 10'd1, 10'd1023);    // one is ancestor of the other
      send_item(tal_pkg::KIND_QUERY, 10'd1023, 10'd1);
      send_item(tal_pkg::KIND_QUERY, 10'd1, 10'd5);       // different trees
      send_item(tal_pkg::KIND_QUERY, 10'd5, 10'd5);
      send_item(tal_pkg::KIND_QUERY, 10'd0, 10'd3);       // sentinel node
      send_item(tal_pkg::KIND_QUERY, 10'd3, 10'd0);
      send_item(tal_pkg::KIND_QUERY, 10'd700, 10'd3);     // unattached node
      send_item(tal_pkg::KIND_QUERY, 10'd1023, 10'd1022);
   endtask

   task automatic test_random_forest(input int count);
      repeat (count) random_item();
   endtask

   task automatic test_level_extremes();
      write_levels(4'd0);      // single-step lifting only
      test_random_forest(40);
      write_levels(4'd15);     // saturates to the top level
      test_random_forest(40);
      write_levels(4'd1);
      test_random_forest(40);
   endtask

   task automatic test_backpressure();
      wait_for_drain();
      rsp_hold_req = 1'b1;
      test_random_forest(24);
      // sender waits here until every answer is back
      wait_for_drain();
   endtask

   initial begin : main
      int j;
      tal_pkg::node_type t;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= tal_pkg::KIND_ATTACH;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_attach_rules();
      test_query_rules();

      for (int n = 1; n < NODES; n++) begin
         if (!is_placed(tal_pkg::node_type'(n))) begin
            free_nodes.insert(free_nodes.size(), tal_pkg::node_type'(n));
         end
      end
      for (int i = free_nodes.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = free_nodes[i];
         free_nodes[i] = free_nodes[j];
         free_nodes[j] = t;
      end

      test_random_forest(450);
      test_level_extremes();
      test_backpressure();
      write_levels(4'd9);
      test_random_forest(250);
      write_levels(4'd4);
      test_random_forest(200);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/tal_pkg.sv
design/tal_store.sv
design/tree_ancestor_lca_engine.sv
test/tb_tree_ancestor_lca_engine.sv
